/* rtl/core/ght_pkg.sv */
package ght_pkg;

   // table geometry
   localparam int SLOTS         = 256;
   localparam int GEN_BITS      = 16;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int COUNT_BITS    = $clog2(SLOTS + 1);
   localparam int ROW_BITS      = 8;
   localparam int ROWS          = SLOTS / ROW_BITS;
   localparam int ROW_ADDR_BITS = $clog2(ROWS);
   localparam int POS_BITS      = $clog2(ROW_BITS);
   localparam int ROW_CNT_BITS  = $clog2(ROW_BITS + 1);

   // port field widths
   localparam int ACTION_BITS    = 3;
   localparam int INDEX_BITS     = 9;
   localparam int ID_GEN_BITS    = 17;
   localparam int RANK_BITS      = 8;
   localparam int OUT_INDEX_BITS = 8;
   localparam int OUT_GEN_BITS   = 16;
   localparam int TOTAL_BITS     = 9;
   localparam int CAP_BITS       = 9;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(SLOTS);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_CREATE     = 3'd0,
      ACT_LOOKUP_ID  = 3'd1,
      ACT_LOOKUP_RAW = 3'd2,
      ACT_DELETE     = 3'd3,
      ACT_PICK       = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_SCAN,
      ST_PICK_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   // result of searching one row of active marks
   typedef struct packed {
      logic                    hit;
      logic [POS_BITS-1:0]     pos;
      logic [ROW_CNT_BITS-1:0] count;
   } row_pick_type;

   // bits of a row whose slot lies below the fill count
   function automatic logic [ROW_BITS-1:0] row_fill_mask(
      input logic [ROW_ADDR_BITS-1:0] row,
      input logic [COUNT_BITS-1:0]    filled
   );
      logic [ROW_BITS-1:0] mask;
      logic [COUNT_BITS-1:0] slot;
      mask = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         slot    = COUNT_BITS'({row, POS_BITS'(j)});
         mask[j] = slot < filled;
      end
      return mask;
   endfunction

endpackage

/* rtl/core/ght_ram.sv */
module ght_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ght_row_select.sv */
module ght_row_select
   import ght_pkg::*;
(
   input  logic [ROW_BITS-1:0]  row_bits,
   input  logic [RANK_BITS-1:0] rank,
   output row_pick_type         sel
);

   logic [ROW_CNT_BITS-1:0] run;

   // first set bit at which the running count equals the rank
   always_comb begin
      run     = '0;
      sel.hit = 1'b0;
      sel.pos = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         if (row_bits[j]) begin
            if (!sel.hit && (RANK_BITS'(run) == rank)) begin
               sel.hit = 1'b1;
               sel.pos = POS_BITS'(j);
            end
            run = run + ROW_CNT_BITS'(1);
         end
      end
      sel.count = run;
   end

endmodule

/* rtl/core/generational_handle_table.sv */
// Handle table that hands out (index, generation) ids for an outside data
// memory indexed by slot. Slots are filled in order and never reused. One
// request is processed at a time. Create, lookup by id, lookup by raw index,
// delete and a refused random pick pass through these steps between one request
// transfer and the next:
//   - a read of the generation and active-mark memories
//   - an evaluate/write-back step
//   - handing the result to the output register
//   - an idle state to take the next request
// A random pick that succeeds walks the active-mark memory one 8-slot row per
// cycle from row zero to the row of the picked slot, then reads that slot's
// generation and evaluates. The output register lets the next request
// transfer while a result waits. A finished result that finds the register
// still holding a stalled one waits behind it, and the input stays stalled
// until the register frees. Memory is never cleared: entries at or above the
// fill count read as generation zero and inactive; no pass clears it at reset.
module generational_handle_table
   import ght_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ACTION_BITS-1:0]        req_action,
   input  logic signed [INDEX_BITS-1:0]  req_id_index,
   input  logic signed [ID_GEN_BITS-1:0] req_id_generation,
   input  logic [RANK_BITS-1:0]          req_pick_rank,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [OUT_INDEX_BITS-1:0]     rsp_slot_index,
   output logic [OUT_GEN_BITS-1:0]       rsp_slot_generation,
   output logic [TOTAL_BITS-1:0]         rsp_active_total,
   // capacity register
   input  logic                          csr_write_en,
   input  logic [CAP_BITS-1:0]           csr_write_data
);

   // control state
   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   filled_ff, filled_in;
   logic [COUNT_BITS-1:0]   active_ff, active_in;
   logic [CAP_BITS-1:0]     cap_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    scan_live_ff, scan_live_in;

   // captured request
   action_type              action_ff, action_in;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in;
   logic [ID_GEN_BITS-1:0]  gen_ff, gen_in;
   logic [RANK_BITS-1:0]    rank_ff, rank_in;
   logic                    pass_ff, pass_in;

   // pick scan
   logic [ROW_ADDR_BITS-1:0] scan_row_ff, scan_row_in;
   logic [ROW_ADDR_BITS-1:0] scan_data_row_ff, scan_data_row_in;

   // result staging and output register
   logic                    res_ok_ff, res_ok_in;
   logic [SLOT_BITS-1:0]    res_index_ff, res_index_in;
   logic [GEN_BITS-1:0]     res_gen_ff, res_gen_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [SLOT_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [GEN_BITS-1:0]     rsp_gen_ff, rsp_gen_in;
   logic [COUNT_BITS-1:0]   rsp_total_ff, rsp_total_in;

   // memory ports
   logic                     gen_rd_en, gen_we;
   logic [GEN_BITS-1:0]      gen_rdata, gen_wdata;
   logic                     act_rd_en, act_we;
   logic [ROW_ADDR_BITS-1:0] act_rd_addr;
   logic [ROW_BITS-1:0]      act_rdata, act_wdata;

   // request decode
   logic                    req_xfer;
   logic                    rsp_free;
   logic [CAP_BITS-1:0]     cap_eff;
   logic [SLOT_BITS-1:0]    req_slot_raw;
   logic                    req_in_range;
   action_type              req_act;

   // evaluation
   logic [ROW_ADDR_BITS-1:0] slot_row;
   logic [POS_BITS-1:0]      slot_pos;
   logic                     slot_filled;
   logic [GEN_BITS-1:0]      gen_cur, gen_next;
   logic [ROW_BITS-1:0]      row_cur, slot_bit;
   logic                     bit_cur, gen_match;
   logic                     eval_ok, eval_create, eval_clear;
   row_pick_type             sel;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // capacity above the slot count acts as the slot count
   assign cap_eff = (cap_ff > CAP_BITS'(SLOTS)) ? CAP_BITS'(SLOTS) : cap_ff;

   // negative index is out of range; otherwise it must lie below the fill count
   assign req_slot_raw = SLOT_BITS'(req_id_index[INDEX_BITS-2:0]);
   assign req_in_range = !req_id_index[INDEX_BITS-1]
                         && (COUNT_BITS'(req_id_index[INDEX_BITS-2:0]) < filled_ff);
   assign req_act = action_type'(req_action);

   // ---------------------------------------------------------------------
   // memories: one generation per slot, active marks packed into rows
   // ---------------------------------------------------------------------
   ght_ram #(
      .WIDTH(GEN_BITS),
      .DEPTH(SLOTS)
   ) u_gen_ram (
      .clock  (clock),
      .wr_en  (gen_we),
      .wr_addr(slot_ff),
      .wr_data(gen_wdata),
      .rd_en  (gen_rd_en),
      .rd_addr(slot_ff),
      .rd_data(gen_rdata)
   );

   ght_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROWS)
   ) u_act_ram (
      .clock  (clock),
      .wr_en  (act_we),
      .wr_addr(slot_row),
      .wr_data(act_wdata),
      .rd_en  (act_rd_en),
      .rd_addr(act_rd_addr),
      .rd_data(act_rdata)
   );

   // row search for random pick; marks at or above the fill count are masked
   ght_row_select u_row_select (
      .row_bits(act_rdata & row_fill_mask(scan_data_row_ff, filled_ff)),
      .rank    (rank_ff),
      .sel     (sel)
   );

   // ---------------------------------------------------------------------
   // evaluation of the read-back entry
   // ---------------------------------------------------------------------
   assign slot_row    = slot_ff[SLOT_BITS-1:POS_BITS];
   assign slot_pos    = slot_ff[POS_BITS-1:0];
   assign slot_filled = COUNT_BITS'(slot_ff) < filled_ff;
   // never-filled slots read as generation zero and inactive
   assign gen_cur     = slot_filled ? gen_rdata : '0;
   assign gen_next    = gen_cur + GEN_BITS'(1);
   assign row_cur     = act_rdata & row_fill_mask(slot_row, filled_ff);
   assign slot_bit    = ROW_BITS'(1) << slot_pos;
   assign bit_cur     = row_cur[slot_pos];
   // a negative generation never matches a stored one
   assign gen_match   = (gen_ff == ID_GEN_BITS'(gen_cur));

   always_comb begin
      eval_ok     = 1'b0;
      eval_create = 1'b0;
      eval_clear  = 1'b0;
      case (action_ff)
         ACT_CREATE: begin
            eval_ok     = pass_ff;
            eval_create = pass_ff;
         end
         ACT_LOOKUP_ID: begin
            eval_ok = pass_ff && gen_match;
         end
         ACT_LOOKUP_RAW: begin
            eval_ok = pass_ff && bit_cur;
         end
         ACT_DELETE: begin
            eval_ok    = pass_ff && gen_match;
            // repeated delete succeeds without touching the count
            eval_clear = pass_ff && gen_match && bit_cur;
         end
         ACT_PICK: begin
            eval_ok = pass_ff;
         end
         default: begin
            eval_ok = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if ((action_ff == ACT_PICK) && pass_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_SCAN: begin
            // the rank is below the active count, so some filled row hits
            if (scan_live_ff && sel.hit) begin
               state_in = ST_PICK_READ;
            end
         end
         ST_PICK_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs and datapath updates
   // ---------------------------------------------------------------------
   always_comb begin
      action_in        = action_ff;
      slot_in          = slot_ff;
      gen_in           = gen_ff;
      rank_in          = rank_ff;
      pass_in          = pass_ff;
      filled_in        = filled_ff;
      active_in        = active_ff;
      scan_row_in      = scan_row_ff;
      scan_data_row_in = scan_data_row_ff;
      scan_live_in     = scan_live_ff;
      res_ok_in        = res_ok_ff;
      res_index_in     = res_index_ff;
      res_gen_in       = res_gen_ff;
      rsp_ok_in        = rsp_ok_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_gen_in       = rsp_gen_ff;
      rsp_total_in     = rsp_total_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      gen_rd_en        = 1'b0;
      gen_we           = 1'b0;
      gen_wdata        = gen_next;
      act_rd_en        = 1'b0;
      act_rd_addr      = slot_row;
      act_we           = 1'b0;
      act_wdata        = row_cur | slot_bit;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               action_in = req_act;
               gen_in    = ID_GEN_BITS'(req_id_generation);
               rank_in   = req_pick_rank;
               // out-of-range requests still address slot zero
               slot_in   = req_in_range ? req_slot_raw : '0;
               case (req_act) inside
                  ACT_CREATE: begin
                     slot_in = SLOT_BITS'(filled_ff);
                     pass_in = filled_ff < COUNT_BITS'(cap_eff);
                  end
                  ACT_LOOKUP_ID, ACT_LOOKUP_RAW, ACT_DELETE: begin
                     pass_in = req_in_range;
                  end
                  ACT_PICK: begin
                     pass_in = COUNT_BITS'(req_pick_rank) < active_ff;
                  end
                  default: begin
                     pass_in = 1'b0;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            gen_rd_en    = 1'b1;
            act_rd_en    = 1'b1;
            scan_row_in  = '0;
            scan_live_in = 1'b0;
         end
         ST_SCAN: begin
            // one row read issued per cycle, the previous row evaluated
            act_rd_en        = 1'b1;
            act_rd_addr      = scan_row_ff;
            scan_row_in      = scan_row_ff + ROW_ADDR_BITS'(1);
            scan_data_row_in = scan_row_ff;
            scan_live_in     = 1'b1;
            if (scan_live_ff) begin
               if (sel.hit) begin
                  slot_in = {scan_data_row_ff, sel.pos};
               end else begin
                  rank_in = rank_ff - RANK_BITS'(sel.count);
               end
            end
         end
         ST_PICK_READ: begin
            gen_rd_en = 1'b1;
         end
         ST_EVAL: begin
            // read-modify-write of the entry, then stage the result
            if (eval_create) begin
               gen_we    = 1'b1;
               act_we    = 1'b1;
               act_wdata = row_cur | slot_bit;
               filled_in = filled_ff + COUNT_BITS'(1);
               active_in = active_ff + COUNT_BITS'(1);
            end else if (eval_clear) begin
               act_we    = 1'b1;
               act_wdata = row_cur & ~slot_bit;
               active_in = active_ff - COUNT_BITS'(1);
            end
            res_ok_in    = eval_ok;
            res_index_in = eval_ok ? slot_ff : '0;
            if (!eval_ok) begin
               res_gen_in = '0;
            end else if (eval_create) begin
               res_gen_in = gen_next;
            end else begin
               res_gen_in = gen_cur;
            end
         end
         ST_DONE: begin
            // active count already holds its value after this request
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_index_in = res_index_ff;
               rsp_gen_in   = res_gen_ff;
               rsp_total_in = active_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         active_ff    <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         scan_live_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_live_ff <= scan_live_in;
         if (csr_write_en) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      slot_ff          <= slot_in;
      gen_ff           <= gen_in;
      rank_ff          <= rank_in;
      pass_ff          <= pass_in;
      scan_row_ff      <= scan_row_in;
      scan_data_row_ff <= scan_data_row_in;
      res_ok_ff        <= res_ok_in;
      res_index_ff     <= res_index_in;
      res_gen_ff       <= res_gen_in;
      rsp_ok_ff        <= rsp_ok_in;
      rsp_index_ff     <= rsp_index_in;
      rsp_gen_ff       <= rsp_gen_in;
      rsp_total_ff     <= rsp_total_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_slot_index      = OUT_INDEX_BITS'(rsp_index_ff);
   assign rsp_slot_generation = OUT_GEN_BITS'(rsp_gen_ff);
   assign rsp_active_total    = TOTAL_BITS'(rsp_total_ff);

endmodule
